// File: hdl/mdse_pkg.sv
`default_nettype none
package mdse_pkg;
    localparam int NODES = 1024;
    localparam logic [31:0] TIME_STEP_RESET = 32'd4294967;
    localparam logic [31:0] RATIO_MAX = 32'h7FFF_FFFF;
    localparam logic [18:0] DIV6_RECIP = 19'd349526; // ceil(2^21 / 6)
    localparam logic REQ_SNAPSHOT = 1'b0;
    localparam logic REQ_ACCUM = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [9:0]        node_index;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic              last_node;
    } mdse_in_t;

    typedef struct packed {
        logic [63:0] error_value;
        logic        zero_step_seen;
    } mdse_out_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_LAG, OP_SQ, OP_RDIV, OP_RSQ, OP_SQRT, OP_CPL,
        OP_SUM, OP_DT, OP_DIV6, OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic       start;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } sts_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction
endpackage
`default_nettype wire

// File: hdl/md_step_error_estimator_core.sv
// channel  | ports                      | payload
// request  | s_valid / s_ready          | s_data (mdse_in_t)
// result   | m_valid / m_ready          | m_data (mdse_out_t)
// config   | cfg_we / cfg_wdata         | time_step
// Snapshot requests arriving while idle are accepted in the cycle they arrive. Accumulate
// requests run three divisions and a square root in one shared iterative unit; a zero
// position change skips its division. The last node adds the sum, dt scaling and /6,
// plus any wait for the output register.
// Synchronous active-low reset clears sums, flag and control and restores dt.
// The result sits in an output register; the request side waits only for it to free.
`default_nettype none
module md_step_error_estimator_core
    import mdse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire mdse_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output mdse_out_t        m_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);
    logic [31:0] time_step_reg;
    logic        snap_we, res_load, out_valid_reg;
    mdse_out_t   out_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic [63:0] err;
    logic        zf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) time_step_reg <= cfg_wdata;
            if (res_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) out_reg <= '{error_value: err, zero_step_seen: zf};
    end

    mdse_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_valid),
        .in_ready (s_ready),
        .req_type (s_data.req_type),
        .last_node(s_data.last_node),
        .snap_we, .res_load,
        .res_free (!out_valid_reg || m_ready),
        .cmd, .sts
    );

    mdse_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .item       (s_data),
        .snap_we,
        .time_step  (time_step_reg),
        .error_value(err),
        .zero_flag  (zf)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

// File: hdl/mdse_datapath.sv
`default_nettype none
module mdse_datapath
    import mdse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire mdse_in_t    item,
    input  wire logic        snap_we,
    input  wire logic [31:0] time_step,
    output logic [63:0]      error_value,
    output logic             zero_flag
);
    logic [31:0] lfx_mem [NODES], lfy_mem [NODES], lfz_mem [NODES];
    logic [31:0] lpx_mem [NODES], lpy_mem [NODES], lpz_mem [NODES];
    logic [31:0] lag_f_reg [3], lag_p_reg [3];
    logic [63:0] force_sum_reg, coupling_sum_reg, v2_reg, f2_reg;
    logic [31:0] ratio_reg [3];
    logic [63:0] rsq_reg, len_reg, s_reg;
    logic        zero_reg;

    // shared iterative divider / sqrt unit, one bit per cycle
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] num_reg, quo_reg;
    logic [64:0] rem_reg;
    logic [32:0] den_reg;
    logic        mode_reg; // 0 divide, 1 sqrt
    logic [63:0] sq_root_reg;

    logic [32:0] df, dp;
    logic [31:0] fsel, lfsel, psel, lpsel;
    logic [64:0] trial;
    logic [31:0] vsel;

    always_comb begin
        fsel  = (cmd.sel == 2'd0) ? item.force_x : (cmd.sel == 2'd1) ? item.force_y : item.force_z;
        psel  = (cmd.sel == 2'd0) ? item.pos_x : (cmd.sel == 2'd1) ? item.pos_y : item.pos_z;
        vsel  = (cmd.sel == 2'd0) ? item.vel_x : (cmd.sel == 2'd1) ? item.vel_y : item.vel_z;
        lfsel = lag_f_reg[cmd.sel];
        lpsel = lag_p_reg[cmd.sel];
        df = {fsel[31], fsel} - {lfsel[31], lfsel};
        dp = {psel[31], psel} - {lpsel[31], lpsel};
        if (df[32]) df = -df;
        if (dp[32]) dp = -dp;
        trial  = {rem_reg[63:0], num_reg[63]} - {32'd0, den_reg};
    end

    logic [31:0] fm, vm;
    logic [63:0] fsq, vsq, rsq1;
    always_comb begin
        fm = fsel[31] ? 32'(-fsel) : fsel;
        vm = vsel[31] ? 32'(-vsel) : vsel;
        fsq = fm * fm;
        vsq = vm * vm;
        rsq1 = ratio_reg[cmd.sel] * ratio_reg[cmd.sel];
    end

    // divide by six, 16 bits a step: reciprocal multiply of remainder and digit
    logic [18:0] d6_w, d6_r;
    logic [37:0] d6_p;
    logic [15:0] d6_q;
    always_comb begin
        d6_w = {rem_reg[2:0], num_reg[63:48]};
        d6_p = 38'(d6_w) * 38'(DIV6_RECIP);
        d6_q = d6_p[36:21];
        d6_r = d6_w - ({1'b0, d6_q, 2'b00} + {2'b00, d6_q, 1'b0});
    end

    // multiply of 64-bit value by 32-bit, done as two halves in turn
    logic [63:0] mh_reg;
    logic        mstep_reg;
    logic [63:0] mop_a;
    logic [31:0] mop_b;
    logic [63:0] mhalf;
    always_comb begin
        mop_a = (cmd.op == OP_CPL) ? v2_reg : s_reg;
        mop_b = (cmd.op == OP_CPL) ? len_reg[31:0] : time_step;
        mhalf = (mstep_reg ? mop_a[31:0] : mop_a[63:32]) * mop_b;
    end

    always_ff @(posedge aclk) begin
        if (snap_we) begin
            lfx_mem[item.node_index] <= item.force_x;
            lfy_mem[item.node_index] <= item.force_y;
            lfz_mem[item.node_index] <= item.force_z;
            lpx_mem[item.node_index] <= item.pos_x;
            lpy_mem[item.node_index] <= item.pos_y;
            lpz_mem[item.node_index] <= item.pos_z;
        end
        if (cmd.op == OP_LAG) begin
            lag_f_reg[0] <= lfx_mem[item.node_index];
            lag_f_reg[1] <= lfy_mem[item.node_index];
            lag_f_reg[2] <= lfz_mem[item.node_index];
            lag_p_reg[0] <= lpx_mem[item.node_index];
            lag_p_reg[1] <= lpy_mem[item.node_index];
            lag_p_reg[2] <= lpz_mem[item.node_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_sum_reg    <= '0;
            coupling_sum_reg <= '0;
            zero_reg         <= 1'b0;
            busy_reg         <= 1'b0;
            mstep_reg        <= 1'b0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    f2_reg  <= '0;
                    v2_reg  <= '0;
                    rsq_reg <= '0;
                end
                OP_SQ: begin
                    f2_reg <= f2_reg + fsq;
                    v2_reg <= v2_reg + vsq;
                end
                OP_RDIV: begin
                    if (cmd.start) begin
                        if (dp == 33'd0) begin
                            ratio_reg[cmd.sel] <= RATIO_MAX;
                            quo_reg <= {32'd0, RATIO_MAX};
                            zero_reg <= 1'b1;
                        end else begin
                            num_reg  <= {15'd0, df, 16'd0};
                            den_reg  <= dp;
                            rem_reg  <= '0;
                            quo_reg  <= '0;
                            cnt_reg  <= 7'd64;
                            busy_reg <= 1'b1;
                            mode_reg <= 1'b0;
                        end
                    end else if (busy_reg) begin
                        num_reg <= {num_reg[62:0], 1'b0};
                        if (!trial[64]) begin
                            rem_reg <= {1'b0, trial[63:0]};
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[63:0], num_reg[63]};
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 7'd1;
                        if (cnt_reg == 7'd1) begin
                            busy_reg <= 1'b0;
                        end
                    end else begin
                        ratio_reg[cmd.sel] <= (quo_reg > {32'd0, RATIO_MAX}) ? RATIO_MAX
                                                                              : quo_reg[31:0];
                    end
                end
                OP_RSQ: rsq_reg <= rsq_reg + rsq1;
                OP_SQRT: begin
                    if (cmd.start) begin
                        num_reg     <= rsq_reg;
                        rem_reg     <= '0;
                        sq_root_reg <= '0;
                        cnt_reg     <= 7'd32;
                        busy_reg    <= 1'b1;
                        mode_reg    <= 1'b1;
                    end else if (busy_reg) begin
                        num_reg <= {num_reg[61:0], 2'b00};
                        if ({rem_reg[62:0], num_reg[63:62]} >= {sq_root_reg[62:0], 2'b01}) begin
                            rem_reg <= {rem_reg[62:0], num_reg[63:62]} -
                                       {sq_root_reg[62:0], 2'b01};
                            sq_root_reg <= {sq_root_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[62:0], num_reg[63:62]};
                            sq_root_reg <= {sq_root_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 7'd1;
                        if (cnt_reg == 7'd1) begin
                            busy_reg <= 1'b0;
                        end
                    end else begin
                        len_reg <= sq_root_reg;
                    end
                end
                OP_CPL, OP_DT: begin
                    // 64x32 in two halves: high half first, then low half and combine
                    if (!mstep_reg) begin
                        mh_reg    <= mhalf;
                        mstep_reg <= 1'b1;
                    end else begin
                        mstep_reg <= 1'b0;
                        if (cmd.op == OP_CPL) begin
                            force_sum_reg <= sat_add(force_sum_reg, f2_reg);
                            if (mh_reg[63:48] != 16'd0) begin
                                coupling_sum_reg <= '1;
                            end else begin
                                coupling_sum_reg <= sat_add(coupling_sum_reg,
                                    sat_add({mh_reg[47:0], 16'd0}, {16'd0, mhalf[63:16]}));
                            end
                        end else begin
                            s_reg <= mh_reg + {32'd0, mhalf[63:32]};
                        end
                    end
                end
                OP_SUM: begin
                    s_reg <= sat_add(force_sum_reg, coupling_sum_reg);
                end
                OP_DIV6: begin
                    if (cmd.start) begin
                        num_reg  <= s_reg;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= 7'd4;
                        busy_reg <= 1'b1;
                        mode_reg <= 1'b0;
                    end else if (busy_reg) begin
                        num_reg <= {num_reg[47:0], 16'd0};
                        rem_reg <= {62'd0, d6_r[2:0]};
                        quo_reg <= {quo_reg[47:0], d6_q};
                        cnt_reg <= cnt_reg - 7'd1;
                        if (cnt_reg == 7'd1) begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
                OP_CLEAR: begin
                    force_sum_reg    <= '0;
                    coupling_sum_reg <= '0;
                    zero_reg         <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    logic unused;
    assign unused = ^{mode_reg, item.req_type, item.last_node, d6_p, d6_r};
    assign sts.busy   = busy_reg | mstep_reg;
    assign error_value = quo_reg;
    assign zero_flag  = zero_reg;
endmodule
`default_nettype wire

// File: hdl/mdse_ctrl.sv
`default_nettype none
module mdse_ctrl
    import mdse_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     req_type,
    input  wire logic     last_node,
    output logic          snap_we,
    output logic          res_load,
    input  wire logic     res_free,
    output cmd_t          cmd,
    input  wire sts_t     sts
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LAG   = 12'b000000000010,
        S_SQ    = 12'b000000000100,
        S_RDIV  = 12'b000000001000,
        S_RSQ   = 12'b000000010000,
        S_SQRT  = 12'b000000100000,
        S_CPL   = 12'b000001000000,
        S_SUM   = 12'b000010000000,
        S_DT    = 12'b000100000000,
        S_DIV6  = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       go_reg, go_next;
    logic       wait_reg, wait_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            go_reg    <= 1'b0;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            go_reg    <= go_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        go_next    = 1'b0;
        wait_next  = wait_reg;
        in_ready   = 1'b0;
        snap_we    = 1'b0;
        res_load   = 1'b0;
        cmd        = '{op: OP_NONE, sel: sel_reg, start: go_reg};
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (req_type == REQ_SNAPSHOT) begin
                        in_ready = 1'b1;
                        snap_we  = 1'b1;
                    end else begin
                        cmd.op     = OP_LOAD;
                        state_next = S_LAG;
                    end
                end
            end
            S_LAG: begin
                cmd.op = OP_LAG;
                sel_next = 2'd0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op = OP_SQ;
                if (sel_reg == 2'd2) begin
                    sel_next = 2'd0;
                    go_next = 1'b1;
                    wait_next = 1'b0;
                    state_next = S_RDIV;
                end else begin
                    sel_next = sel_reg + 2'd1;
                end
            end
            S_RDIV: begin
                cmd.op = OP_RDIV;
                if (!go_reg && !sts.busy) begin
                    if (wait_reg) begin
                        wait_next = 1'b0;
                        if (sel_reg == 2'd2) begin
                            sel_next = 2'd0;
                            state_next = S_RSQ;
                        end else begin
                            sel_next = sel_reg + 2'd1;
                            go_next = 1'b1;
                        end
                    end else begin
                        // capture quotient next cycle
                        cmd.op = OP_NONE;
                        wait_next = 1'b1;
                    end
                end
            end
            S_RSQ: begin
                cmd.op = OP_RSQ;
                if (sel_reg == 2'd2) begin
                    go_next = 1'b1;
                    wait_next = 1'b0;
                    state_next = S_SQRT;
                end else begin
                    sel_next = sel_reg + 2'd1;
                end
            end
            S_SQRT: begin
                cmd.op = OP_SQRT;
                if (!go_reg && !sts.busy) begin
                    state_next = S_CPL;
                end
            end
            S_CPL: begin
                cmd.op = OP_CPL;
                if (wait_reg) begin
                    wait_next = 1'b0;
                    in_ready = !last_node;
                    state_next = last_node ? S_SUM : S_IDLE;
                end else begin
                    wait_next = 1'b1;
                end
                if (!last_node && wait_reg) begin
                    cmd.op = OP_CPL;
                end
            end
            S_SUM: begin
                cmd.op = OP_SUM;
                sel_next = 2'd0;
                wait_next = 1'b0;
                state_next = S_DT;
            end
            S_DT: begin
                cmd.op = OP_DT;
                if (wait_reg) begin
                    wait_next = 1'b0;
                    if (sel_reg == 2'd2) begin
                        go_next = 1'b1;
                        state_next = S_DIV6;
                    end else begin
                        sel_next = sel_reg + 2'd1;
                    end
                end else begin
                    wait_next = 1'b1;
                end
            end
            S_DIV6: begin
                cmd.op = OP_DIV6;
                if (!go_reg && !sts.busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (res_free) begin
                    res_load = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                cmd.op = OP_CLEAR;
                in_ready = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: bench/md_step_error_estimator_core_check.sv
module md_step_error_estimator_core_check
    import mdse_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire mdse_in_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire mdse_out_t   m_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    logic [31:0] lag_fx [NODES];
    logic [31:0] lag_fy [NODES];
    logic [31:0] lag_fz [NODES];
    logic [31:0] lag_px [NODES];
    logic [31:0] lag_py [NODES];
    logic [31:0] lag_pz [NODES];
    logic [63:0] force_acc;
    logic [63:0] coupling_acc;
    logic        zero_seen;
    logic [31:0] dt_reg;
    mdse_out_t   error_queue[$];

    assign pending = error_queue.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] sq3(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic signed [31:0] c);
        logic signed [63:0] x, y, z;
        x = a; y = b; z = c;
        return x * x + y * y + z * z;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] diff_ratio(input logic signed [31:0] f,
                                               input logic signed [31:0] lf,
                                               input logic signed [31:0] p,
                                               input logic signed [31:0] lp,
                                               inout logic zflag);
        logic signed [63:0] df, dp;
        logic [63:0] q;
        df = 64'(f) - 64'(lf);
        dp = 64'(p) - 64'(lp);
        if (df < 0) df = -df;
        if (dp < 0) dp = -dp;
        if (dp == 0) begin
            zflag = 1'b1;
            return 64'(RATIO_MAX);
        end
        q = (64'(df) << 16) / 64'(dp);
        return q > 64'(RATIO_MAX) ? 64'(RATIO_MAX) : q;
    endfunction

    function automatic logic [63:0] scale(input logic [63:0] a, input logic [31:0] b,
                                          input int sh);
        logic [95:0] p;
        p = {32'b0, a} * {64'b0, b};
        p = p >> sh;
        return p[95:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    task automatic predict_error(input mdse_in_t r);
        logic [31:0] lfx, lfy, lfz, lpx, lpy, lpz;
        logic [63:0] rx, ry, rz, len, s;
        mdse_out_t e;
        if (r.req_type == REQ_SNAPSHOT) begin
            lag_fx[r.node_index] = r.force_x;
            lag_fy[r.node_index] = r.force_y;
            lag_fz[r.node_index] = r.force_z;
            lag_px[r.node_index] = r.pos_x;
            lag_py[r.node_index] = r.pos_y;
            lag_pz[r.node_index] = r.pos_z;
            return;
        end
        lfx = lag_fx[r.node_index]; lfy = lag_fy[r.node_index]; lfz = lag_fz[r.node_index];
        lpx = lag_px[r.node_index]; lpy = lag_py[r.node_index]; lpz = lag_pz[r.node_index];
        force_acc = add_sat(force_acc, sq3(r.force_x, r.force_y, r.force_z));
        rx = diff_ratio(r.force_x, lfx, r.pos_x, lpx, zero_seen);
        ry = diff_ratio(r.force_y, lfy, r.pos_y, lpy, zero_seen);
        rz = diff_ratio(r.force_z, lfz, r.pos_z, lpz, zero_seen);
        len = root64(rx * rx + ry * ry + rz * rz);
        coupling_acc = add_sat(coupling_acc,
                               scale(sq3(r.vel_x, r.vel_y, r.vel_z), len[31:0], 16));
        if (!r.last_node) return;
        s = add_sat(force_acc, coupling_acc);
        s = scale(s, dt_reg, 32);
        s = scale(s, dt_reg, 32);
        s = scale(s, dt_reg, 32);
        e.error_value = s / 6;
        e.zero_step_seen = zero_seen;
        error_queue.push_back(e);
        force_acc = 0;
        coupling_acc = 0;
        zero_seen = 0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            force_acc = 0;
            coupling_acc = 0;
            zero_seen = 0;
            dt_reg = TIME_STEP_RESET;
            fail_count = 0;
        end else begin
            if (cfg_we) dt_reg = cfg_wdata;
            // the last request and its result can complete at the same edge
            if (s_valid && s_ready) predict_error(s_data);
            if (m_valid && m_ready) begin
                if (error_queue.size() == 0) begin
                    report("unexpected", m_data.error_value, 0);
                end else begin
                    if (m_data.error_value !== error_queue[0].error_value)
                        report("error_value", m_data.error_value, error_queue[0].error_value);
                    if (m_data.zero_step_seen !== error_queue[0].zero_step_seen)
                        report("zero_step_seen", 64'(m_data.zero_step_seen),
                               64'(error_queue[0].zero_step_seen));
                    void'(error_queue.pop_front());
                end
            end
        end
    end
endmodule

// File: bench/md_step_error_estimator_core_test.sv
module md_step_error_estimator_core_test;
    import mdse_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    mdse_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    mdse_out_t   m_data;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          cycles = 0;
    bit          written [NODES];
    int          filled[$];

    always #1 aclk = ~aclk;

    md_step_error_estimator_core dut (.*);
    md_step_error_estimator_core_check checker_inst (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_ready <= ($urandom_range(99) >= recv_stall);
        if (cycles > 3000000) begin
            $display("md_step_error_estimator_core_test NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after acceptance until the next request or an idle cycle
    task automatic send(input mdse_in_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.req_type == REQ_SNAPSHOT && !written[r.node_index]) begin
            written[r.node_index] = 1;
            filled.push_back(r.node_index);
        end
    endtask

    task automatic node_item(input logic kind, input logic [9:0] idx, input logic last);
        mdse_in_t r;
        r.req_type = kind;
        r.node_index = idx;
        r.force_x = pick32(); r.force_y = pick32(); r.force_z = pick32();
        r.vel_x = pick32(); r.vel_y = pick32(); r.vel_z = pick32();
        r.pos_x = pick32(); r.pos_y = pick32(); r.pos_z = pick32();
        r.last_node = last;
        send(r);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic set_dt(input logic [31:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic pass_run(input int nodes);
        int k;
        for (k = 0; k < nodes; k++)
            node_item(REQ_ACCUM, 10'(filled[$urandom_range(filled.size() - 1)]),
                      k == nodes - 1);
    endtask

    initial begin
        mdse_in_t r;
        int i;
        int phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, zero position change, ignored last on snapshot
        r = '0;
        r.req_type = REQ_SNAPSHOT; r.node_index = 0; r.last_node = 1;
        send(r);
        r.req_type = REQ_ACCUM; r.last_node = 1;
        send(r);
        r.node_index = 10'h3FF; r.req_type = REQ_SNAPSHOT;
        r.force_x = 32'h8000_0000; r.force_y = 32'h7FFF_FFFF; r.force_z = 32'h8000_0000;
        r.pos_x = 32'h8000_0000; r.pos_y = 32'h7FFF_FFFF; r.pos_z = 0;
        send(r);
        r.req_type = REQ_ACCUM;
        r.force_x = 32'h7FFF_FFFF; r.force_y = 32'h8000_0000; r.force_z = 32'h7FFF_FFFF;
        r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000; r.pos_z = 1;
        r.vel_x = 32'h8000_0000; r.vel_y = 32'h8000_0000; r.vel_z = 32'h7FFF_FFFF;
        send(r);
        set_dt(32'hFFFF_FFFF);
        send(r);
        r.pos_z = 0;
        send(r);
        for (i = 0; i < 8; i++) node_item(REQ_SNAPSHOT, 10'($urandom), 1'($urandom));
        pass_run(4);
        set_dt(0);
        pass_run(2);
        set_dt(32'h0100_0000);
        for (phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 54 : 32) : 0;
            recv_stall = (phase == 2) ? 54 : (phase == 3 ? 32 : 0);
            set_dt(phase == 0 ? $urandom : (phase == 1 ? 32'h8000_0000 : $urandom_range(1 << 26)));
            for (i = 0; i < 325; ) begin
                if ($urandom_range(9) < 3) begin
                    node_item(REQ_SNAPSHOT, 10'($urandom), 1'($urandom));
                    i++;
                end else begin
                    int n;
                    n = $urandom_range(1, 5);
                    pass_run(n);
                    i += n;
                end
                if (i % 97 == 0) drain();
            end
        end
        drain();
        if (fail_count == 0) begin
            $display("md_step_error_estimator_core_test OK");
        end else begin
            $display("md_step_error_estimator_core_test NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/mdse_pkg.sv
hdl/mdse_datapath.sv
hdl/mdse_ctrl.sv
hdl/md_step_error_estimator_core.sv
bench/md_step_error_estimator_core_check.sv
bench/md_step_error_estimator_core_test.sv
